// ----- rtl/diff_drive_odometry_fusion_top_defines.svh -----
// Assertion macros used by the odometry fusion sequencer (ddof_ctrl).
// Depends on nothing; define NO_ASSERTIONS to drop all checks.
`ifndef DIFF_DRIVE_ODOMETRY_FUSION_TOP_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_FUSION_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DDOF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DDOF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DDOF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DDOF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/ddof_pkg.sv -----
// Shared types, constants and CORDIC table for the odometry fusion block.
// Depends on nothing.
package ddof_pkg;
  localparam int CalibSamplesDef = 256;
  localparam int CordicStepsDef  = 16;
  localparam int CordicMax       = 24;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  localparam logic [2:0] CFG_DIST  = 3'd0;
  localparam logic [2:0] CFG_ANGLE = 3'd1;
  localparam logic [2:0] CFG_GYRO  = 3'd2;
  localparam logic [2:0] CFG_ALPHA = 3'd3;
  localparam logic [2:0] CFG_SX    = 3'd4;
  localparam logic [2:0] CFG_SY    = 3'd5;
  localparam logic [2:0] CFG_SH    = 3'd6;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_CALIB = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;
  localparam logic [1:0] OP_LOAD  = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL1 = 8'b0000_0010,
    S_MUL2 = 8'b0000_0100,
    S_MUL3 = 8'b0000_1000,
    S_ROT  = 8'b0001_0000,
    S_POS  = 8'b0010_0000,
    S_WB   = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic mul3;
    logic rot_init;
    logic rot_step;
    logic pos;
    logic wb;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       rot_done;
  } sts_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0: atan_turn = 32'd536870912;   5'd1: atan_turn = 32'd316933406;
      5'd2: atan_turn = 32'd167458907;   5'd3: atan_turn = 32'd85004756;
      5'd4: atan_turn = 32'd42667331;    5'd5: atan_turn = 32'd21354465;
      5'd6: atan_turn = 32'd10679838;    5'd7: atan_turn = 32'd5340245;
      5'd8: atan_turn = 32'd2670163;     5'd9: atan_turn = 32'd1335087;
      5'd10: atan_turn = 32'd667544;     5'd11: atan_turn = 32'd333772;
      5'd12: atan_turn = 32'd166886;     5'd13: atan_turn = 32'd83443;
      5'd14: atan_turn = 32'd41722;      5'd15: atan_turn = 32'd20861;
      5'd16: atan_turn = 32'd10430;      5'd17: atan_turn = 32'd5215;
      5'd18: atan_turn = 32'd2608;       5'd19: atan_turn = 32'd1304;
      5'd20: atan_turn = 32'd652;        5'd21: atan_turn = 32'd326;
      5'd22: atan_turn = 32'd163;        5'd23: atan_turn = 32'd81;
      default: atan_turn = 32'd0;
    endcase
  endfunction
endpackage

// ----- rtl/diff_drive_odometry_fusion_top.sv -----
// Start, calibration and reload go through load and write-back only; an update
// also runs the multiply stages, the CORDIC_STEPS-iteration CORDIC and the position step.
// One item at a time; the result register holds until transferred.
// Synchronous active-low reset restores register defaults and a zero pose.
// Depends on ddof_pkg, ddof_ctrl and ddof_dp.
module diff_drive_odometry_fusion_top
  import ddof_pkg::*;
#(
  parameter int CALIB_SAMPLES = CalibSamplesDef,
  parameter int CORDIC_STEPS  = CordicStepsDef
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_count_left,
  input  logic signed [31:0] in_count_right,
  input  logic signed [15:0] in_gyro_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [15:0] out_heading,
  output logic               out_bias_ready,
  output logic signed [23:0] out_gyro_bias,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  cmd_t cmd;
  sts_t sts;

  ddof_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  ddof_dp #(.CALIB_SAMPLES(CALIB_SAMPLES), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_op, .in_count_left, .in_count_right,
    .in_gyro_sample, .cfg_we, .cfg_index, .cfg_data, .out_pos_x, .out_pos_y,
    .out_heading, .out_bias_ready, .out_gyro_bias
  );
endmodule

// ----- rtl/ddof_ctrl.sv -----
// Sequencer for the odometry fusion block: accepts items, steps the datapath.
// Depends on ddof_pkg and the assertion macro header.
`include "diff_drive_odometry_fusion_top_defines.svh"
module ddof_ctrl
  import ddof_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        if (sts.op == OP_STEP) begin
          cmd.mul1 = 1'b1;
          state_nxt = S_MUL2;
        end else begin
          cmd.wb = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3 = 1'b1;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        if (sts.rot_done) begin
          state_nxt = S_POS;
        end else begin
          cmd.rot_step = 1'b1;
        end
      end
      S_POS: begin
        cmd.pos = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        cmd.wb = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.rot_init = cmd.mul3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  `DDOF_ASSERT_NXT(a_load_leaves_idle, clk, rst_n, in_valid && in_ready, !in_ready)
  `DDOF_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `DDOF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

// ----- rtl/ddof_dp.sv -----
// Datapath for the odometry fusion block: pose, calibration, filter, CORDIC.
// Depends on ddof_pkg; driven by ddof_ctrl commands.
module ddof_dp
  import ddof_pkg::*;
#(
  parameter int CALIB_SAMPLES = CalibSamplesDef,
  parameter int CORDIC_STEPS  = CordicStepsDef
)(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_count_left,
  input  logic signed [31:0] in_count_right,
  input  logic signed [15:0] in_gyro_sample,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [15:0] out_heading,
  output logic               out_bias_ready,
  output logic signed [23:0] out_gyro_bias
);
  localparam int CW = $clog2(CALIB_SAMPLES + 1);
  localparam int SH = $clog2(CALIB_SAMPLES);
  localparam bit POW2 = ((1 << SH) == CALIB_SAMPLES);
  localparam int IW = 5;
  localparam logic [33:0] RECIP =
    34'(((64'd1 << (32 + SH)) + 64'(CALIB_SAMPLES - 1)) / 64'(CALIB_SAMPLES));

  logic [19:0] dist_r;
  logic [23:0] angle_r, gain_r;
  logic [16:0] alpha_r;
  logic [31:0] sx_r, sy_r;
  logic [15:0] sh_r;

  logic [31:0] px_r, py_r, ll_r, lr_r;
  logic [15:0] ph_r;
  logic signed [23:0] bias_r, csum_r;
  logic [CW-1:0] ccnt_r;
  logic cdone_r;

  logic [1:0] op_r;
  logic [31:0] cl_r, cr_r;
  logic signed [15:0] g_r;

  logic signed [52:0] lq_r, rq_r;
  logic signed [63:0] enc_r, gyr_r;
  logic signed [34:0] cen_r;
  logic signed [31:0] dth_r;

  logic signed [33:0] cx_r, cy_r;
  logic signed [33:0] cz_r;
  logic flip_r;
  logic [IW-1:0] it_r;
  logic signed [31:0] nx_r, ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= 20'd65536; angle_r <= 24'd6835000; gain_r <= 24'd65536;
      alpha_r <= 17'd62259; sx_r <= '0; sy_r <= '0; sh_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIST:  dist_r  <= cfg_data[19:0];
        CFG_ANGLE: angle_r <= cfg_data[23:0];
        CFG_GYRO:  gain_r  <= cfg_data[23:0];
        CFG_ALPHA: alpha_r <= cfg_data[16:0];
        CFG_SX:    sx_r    <= cfg_data;
        CFG_SY:    sy_r    <= cfg_data;
        CFG_SH:    sh_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op; cl_r <= in_count_left; cr_r <= in_count_right; g_r <= in_gyro_sample;
    end
  end

  // stage 1: wheel travel
  logic signed [31:0] dl, dr;
  assign dl = cl_r - ll_r;
  assign dr = cr_r - lr_r;

  // stage 2: centre, clamped difference, gyro product
  logic signed [53:0] lsum, ldif;
  logic signed [39:0] dclamp;
  logic signed [48:0] censh;
  logic signed [24:0] corr;
  always_comb begin
    lsum = 54'(lq_r) + 54'(rq_r);
    ldif = 54'(lq_r) - 54'(rq_r);
    censh = 49'(lsum >>> 5);
    if (ldif > 54'sd549755813887) dclamp = 40'sd549755813887;
    else if (ldif < -54'sd549755813887) dclamp = -40'sd549755813887;
    else dclamp = 40'(ldif);
    corr = 25'(bias_r) - (25'(g_r) <<< 8);
  end

  // stage 3: blend
  logic signed [31:0] encc, gyrc;
  logic signed [17:0] a, na;
  logic signed [50:0] bl;
  always_comb begin
    if (enc_r > 64'sd2147483647) encc = 32'h7fffffff;
    else if (enc_r < -64'sd2147483648) encc = 32'h80000000;
    else encc = 32'(enc_r);
    if (gyr_r > 64'sd2147483647) gyrc = 32'h7fffffff;
    else if (gyr_r < -64'sd2147483648) gyrc = 32'h80000000;
    else gyrc = 32'(gyr_r);
    a  = (alpha_r > 17'd65536) ? 18'sd65536 : $signed({1'b0, alpha_r});
    na = 18'sd65536 - a;
    bl = 51'(a) * 51'(gyrc) + 51'(na) * 51'(encc);
  end

  logic [31:0] mid;
  assign mid = {ph_r, 16'd0} + 32'(dth_r >>> 1);

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      lq_r <= 53'(dl) * $signed({1'b0, dist_r});
      rq_r <= 53'(dr) * $signed({1'b0, dist_r});
    end
    if (cmd.mul2) begin
      if (censh > 49'sd4294967296) cen_r <= 35'sd4294967296;
      else if (censh < -49'sd4294967296) cen_r <= -35'sd4294967296;
      else cen_r <= 35'(censh);
      enc_r <= 64'((64'(dclamp) * $signed({1'b0, angle_r})) >>> 16);
      gyr_r <= 64'((64'(corr) * $signed({1'b0, gain_r})) >>> 8);
    end
    if (cmd.mul3) dth_r <= 32'(bl >>> 16);
  end

  // CORDIC: first step loads the angle, then one iteration per cycle
  logic signed [33:0] z0;
  logic prep_r;
  assign z0 = 34'($signed(mid));
  always_ff @(posedge clk) begin
    if (cmd.rot_init) begin
      it_r <= '0; prep_r <= 1'b0;
    end else if (cmd.rot_step) begin
      if (!prep_r) begin
        cx_r <= CordicGain; cy_r <= '0; prep_r <= 1'b1;
        if (z0 > 34'sd1073741824) begin
          cz_r <= z0 - 34'sd2147483648; flip_r <= 1'b1;
        end else if (z0 < -34'sd1073741824) begin
          cz_r <= z0 + 34'sd2147483648; flip_r <= 1'b1;
        end else begin
          cz_r <= z0; flip_r <= 1'b0;
        end
      end else begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - (cy_r >>> it_r);
          cy_r <= cy_r + (cx_r >>> it_r);
          cz_r <= cz_r - 34'(atan_turn(it_r));
        end else begin
          cx_r <= cx_r + (cy_r >>> it_r);
          cy_r <= cy_r - (cx_r >>> it_r);
          cz_r <= cz_r + 34'(atan_turn(it_r));
        end
        it_r <= it_r + 1'b1;
      end
    end
  end
  assign sts.rot_done = prep_r && (it_r == IW'(CORDIC_STEPS));
  assign sts.op = op_r;

  // position step
  logic signed [33:0] cc, ss;
  logic signed [68:0] px_m, py_m;
  logic signed [39:0] sxs, sys;
  assign cc = flip_r ? -cx_r : cx_r;
  assign ss = flip_r ? -cy_r : cy_r;
  always_comb begin
    px_m = 69'(cen_r) * 69'(cc);
    py_m = 69'(cen_r) * 69'(ss);
    sxs = 40'($signed(px_r)) + 40'(px_m >>> 30);
    sys = 40'($signed(py_r)) + 40'(py_m >>> 30);
  end
  always_ff @(posedge clk) begin
    if (cmd.pos) begin
      nx_r <= (sxs > 40'sd2147483647) ? 32'h7fffffff :
              (sxs < -40'sd2147483648) ? 32'h80000000 : 32'(sxs);
      ny_r <= (sys > 40'sd2147483647) ? 32'h7fffffff :
              (sys < -40'sd2147483648) ? 32'h80000000 : 32'(sys);
    end
  end

  // calibration
  logic signed [24:0] csum_w;
  logic signed [23:0] csum_c;
  logic signed [35:0] num, anum, q, qs;
  logic [65:0] qm;
  always_comb begin
    csum_w = 25'(csum_r) + 25'(g_r);
    if (csum_w > 25'sd8388607) csum_c = 24'sd8388607;
    else if (csum_w < -25'sd8388608) csum_c = -24'sd8388608;
    else csum_c = 24'(csum_w);
    num = 36'(csum_c) <<< 8;
    anum = num[35] ? -num : num;
    qm = 66'(anum[31:0]) * 66'(RECIP);
    if (POW2) q = anum >>> SH;
    else q = 36'(qm >> (32 + SH));
    qs = num[35] ? -q : q;
  end

  logic [31:0] hsum;
  assign hsum = {ph_r, 16'd0} + dth_r + 32'h8000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0; py_r <= '0; ph_r <= '0; ll_r <= '0; lr_r <= '0;
      bias_r <= '0; csum_r <= '0; ccnt_r <= '0; cdone_r <= 1'b0;
    end else if (cmd.wb) begin
      case (op_r)
        OP_START: begin
          px_r <= sx_r; py_r <= sy_r; ph_r <= sh_r; ll_r <= cl_r; lr_r <= cr_r;
          bias_r <= '0; csum_r <= '0; ccnt_r <= '0; cdone_r <= 1'b0;
        end
        OP_CALIB: begin
          if (!cdone_r) begin
            csum_r <= csum_c;
            ccnt_r <= ccnt_r + 1'b1;
            if (ccnt_r + 1'b1 >= CW'(CALIB_SAMPLES)) begin
              bias_r <= (qs > 36'sd8388607) ? 24'sd8388607 :
                        (qs < -36'sd8388608) ? -24'sd8388608 : 24'(qs);
              cdone_r <= 1'b1;
            end
          end
        end
        OP_STEP: begin
          px_r <= nx_r; py_r <= ny_r; ph_r <= hsum[31:16]; ll_r <= cl_r; lr_r <= cr_r;
        end
        default: begin
          px_r <= sx_r; py_r <= sy_r; ph_r <= sh_r;
        end
      endcase
    end
  end

  assign out_pos_x = px_r;
  assign out_pos_y = py_r;
  assign out_heading = ph_r;
  assign out_bias_ready = cdone_r;
  assign out_gyro_bias = bias_r;
endmodule
